// File: rtl/bcu_pkg.sv
// bcu_pkg: shared types and constants for the bounded counter with undo
// no dependencies; imported by every module of the block
`default_nettype none

package bcu_pkg;

  // width of the operation code
  localparam int unsigned OpW = 3;
  // width of the configuration register index
  localparam int unsigned CfgIdxW = 2;
  // fallback upper limit after a restart with bad settings
  localparam int DefaultHigh = 1000;

  // operation codes; code 7 changes nothing
  typedef enum logic [OpW-1:0] {
    OP_RESTART  = 3'd0,
    OP_ASSIGN   = 3'd1,
    OP_INCR     = 3'd2,
    OP_DECR     = 3'd3,
    OP_ADD      = 3'd4,
    OP_SUB      = 3'd5,
    OP_UNDO     = 3'd6
  } op_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_UPPER = 2'd2
  } cfg_idx_e;

  // sequencer states: run, or waiting for the history read of an undo
  typedef enum logic {
    ST_RUN,
    ST_FETCH
  } bcu_state_e;

  // status from the datapath to the top level
  typedef struct packed {
    logic fire;      // item completes this cycle
    logic fetch;     // history read outstanding
    logic accepted;  // result flag of the completing item
  } bcu_status_t;

endpackage

`default_nettype wire

// File: rtl/bcu_history.sv
// bcu_history: history stack storage, one write port and one registered read port
// depends on bcu_pkg
`default_nettype none

module bcu_history
  import bcu_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  we_i,
  input  wire  [$clog2(HISTORY_DEPTH)-1:0]     waddr_i,
  input  wire  [VALUE_WIDTH-1:0]               wdata_i,
  input  wire                                  re_i,
  input  wire  [$clog2(HISTORY_DEPTH)-1:0]     raddr_i,
  output logic [VALUE_WIDTH-1:0]               rdata_o
);

  logic [VALUE_WIDTH-1:0] mem [HISTORY_DEPTH];
  logic [VALUE_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/bcu_core.sv
// bcu_core: counter state, limits, configuration registers and operation logic
// depends on bcu_pkg and bcu_history
`default_nettype none

module bcu_core
  import bcu_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH   = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire  [CfgIdxW-1:0]                       cfg_idx_i,
  input  wire  [VALUE_WIDTH-1:0]                   cfg_data_i,
  input  wire                                      item_valid_i,
  input  wire  [OpW-1:0]                           item_op_i,
  input  wire  [VALUE_WIDTH-1:0]                   item_amount_i,
  input  wire                                      res_free_i,
  output bcu_status_t                              status_o,
  output logic [VALUE_WIDTH-1:0]                   value_o,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0]       count_o
);

  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned CMP_W = ((W > CW) ? W : CW) + 1;

  // configuration registers
  logic signed [W-1:0] start_q, lower_q, upper_q;

  // counter state
  logic signed [W-1:0] counter_q, counter_d;
  logic signed [W-1:0] low_q, low_d;
  logic signed [W-1:0] high_q, high_d;
  logic [AW-1:0]       top_q, top_d;
  logic [CW-1:0]       held_q, held_d;
  logic                zero0_q;
  bcu_state_e          state_q, state_d;

  // operation logic signals
  logic signed [W-1:0]     amount;
  logic signed [CMP_W-1:0] amt_x, held_x;
  logic signed [W:0]       sum_x;
  logic                    undo_ok, needs_read, push, accepted;
  logic                    fire, rd_en, mem_we;
  logic [AW-1:0]           k_a, undo_top, push_top, mem_waddr;
  logic [CW-1:0]           k_c, push_held;
  logic [W-1:0]            rd_data;
  op_e                     op;

  assign amount = item_amount_i;
  assign op     = op_e'(item_op_i);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      lower_q <= '0;
      upper_q <= W'(DefaultHigh);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START: start_q <= cfg_data_i;
        CFG_LOWER: lower_q <= cfg_data_i;
        CFG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // undo range check and stack pointer arithmetic
  always_comb begin
    amt_x   = CMP_W'(amount);
    held_x  = CMP_W'(held_q);
    undo_ok = (amt_x > 0) && (amt_x < held_x);
    k_a     = AW'(amt_x);
    k_c     = CW'(amt_x);
    if (top_q >= k_a) begin
      undo_top = top_q - k_a;
    end else begin
      undo_top = AW'((AW+1)'(top_q) + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(k_a));
    end
    push_top  = (top_q == AW'(HISTORY_DEPTH - 1)) ? '0 : top_q + 1'b1;
    push_held = (held_q < CW'(HISTORY_DEPTH)) ? held_q + 1'b1 : held_q;
    if (op == OP_SUB) begin
      sum_x = (W+1)'(counter_q) - (W+1)'(amount);
    end else begin
      sum_x = (W+1)'(counter_q) + (W+1)'(amount);
    end
  end

  // next state of the counter for the item in the input register
  always_comb begin
    counter_d  = counter_q;
    low_d      = low_q;
    high_d     = high_q;
    top_d      = top_q;
    held_d     = held_q;
    push       = 1'b0;
    accepted   = 1'b1;
    needs_read = 1'b0;
    mem_waddr  = push_top;
    unique case (op)
      OP_RESTART: begin
        if (start_q > upper_q || start_q < lower_q || upper_q <= lower_q) begin
          low_d     = '0;
          high_d    = W'(DefaultHigh);
          counter_d = '0;
        end else begin
          low_d     = lower_q;
          high_d    = upper_q;
          counter_d = start_q;
        end
        top_d     = '0;
        held_d    = CW'(1);
        push      = 1'b1;
        mem_waddr = '0;
      end
      OP_ASSIGN: begin
        if (amount < low_q) begin
          counter_d = low_q;
        end else if (amount > high_q) begin
          counter_d = high_q;
        end else begin
          counter_d = amount;
        end
        push = 1'b1;
      end
      OP_INCR: begin
        if (counter_q < high_q) begin
          counter_d = counter_q + 1'b1;
          push      = 1'b1;
        end
      end
      OP_DECR: begin
        if (counter_q > low_q) begin
          counter_d = counter_q - 1'b1;
          push      = 1'b1;
        end
      end
      OP_ADD, OP_SUB: begin
        if (sum_x > (W+1)'(high_q)) begin
          counter_d = high_q;
        end else if (sum_x < (W+1)'(low_q)) begin
          counter_d = low_q;
        end else begin
          counter_d = W'(sum_x);
        end
        push = 1'b1;
      end
      OP_UNDO: begin
        if (undo_ok) begin
          needs_read = 1'b1;
          top_d      = undo_top;
          held_d     = held_q - k_c;
          // entry 0 reads as zero until first written
          counter_d  = (undo_top == '0 && zero0_q) ? '0 : rd_data;
        end else begin
          accepted = 1'b0;
        end
      end
      default: ;
    endcase
    if (push && op != OP_RESTART) begin
      top_d  = push_top;
      held_d = push_held;
    end
  end

  // handshake with the input and result registers
  assign fire   = item_valid_i && res_free_i && (!needs_read || state_q == ST_FETCH);
  assign rd_en  = item_valid_i && needs_read && state_q == ST_RUN;
  assign mem_we = fire && push;

  // undo sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN:   if (rd_en) state_d = ST_FETCH;
      ST_FETCH: if (fire)  state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      counter_q <= '0;
      low_q     <= '0;
      high_q    <= W'(DefaultHigh);
      top_q     <= '0;
      held_q    <= CW'(1);
      zero0_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      if (fire) begin
        counter_q <= counter_d;
        low_q     <= low_d;
        high_q    <= high_d;
        top_q     <= top_d;
        held_q    <= held_d;
      end
      if (mem_we && mem_waddr == '0) begin
        zero0_q <= 1'b0;
      end
    end
  end

  // history storage
  bcu_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (counter_d),
    .re_i    (rd_en),
    .raddr_i (undo_top),
    .rdata_o (rd_data)
  );

  assign status_o.fire     = fire;
  assign status_o.fetch    = (state_q == ST_FETCH);
  assign status_o.accepted = accepted;
  assign value_o           = counter_d;
  assign count_o           = held_d;

endmodule

`default_nettype wire

// File: rtl/bounded_counter_with_undo.sv
// bounded_counter_with_undo: top level with input register, result register and checks
// depends on bcu_pkg and bcu_core
//
// Use of the block:
//   Items enter on the s_axis channel (operation and amount) and one result
//   leaves on the m_axis channel for every item (counter value, history
//   count, accepted flag). Limits and start value are set through the plain
//   write port cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only
//   while the block is idle, as the block itself does not enforce it. An
//   accepted item sits in the input register while the operation logic
//   computes the new state, and its result is loaded into the result
//   register at the next edge that finds it free; a successful undo first
//   reads the restored value from the history memory through its registered
//   read port. One item per cycle is sustained while the receiver keeps up,
//   for all operations but a successful undo. A rejected undo reads no history.
//   When the receiver stalls, the result waits in the result register and
//   one further item waits in the input register; s_axis_tready then drops.
//   Reset puts the counter at 0 with limits 0..1000 and one history entry;
//   the history memory needs no clearing pass.
`default_nettype none

module bounded_counter_with_undo
  import bcu_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH   = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // configuration write port
  input  wire                                  cfg_we_i,
  input  wire  [CfgIdxW-1:0]                   cfg_idx_i,
  input  wire  [VALUE_WIDTH-1:0]               cfg_data_i,
  // input items
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: operation, amount
  input  wire  [((OpW + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // result items
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // tdata: current_value, history_count, accepted
  output logic [((VALUE_WIDTH + $clog2(HISTORY_DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int unsigned W      = VALUE_WIDTH;
  localparam int unsigned CW     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned OUT_TW = ((W + CW + 1 + 7) / 8) * 8;

  // input register
  logic           in_valid_q;
  logic [OpW-1:0] in_op_q;
  logic [W-1:0]   in_amount_q;

  // result register
  logic           out_valid_q;
  logic [W-1:0]   out_value_q;
  logic [CW-1:0]  out_count_q;
  logic           out_acc_q;

  bcu_status_t    st;
  logic           res_free;
  logic [W-1:0]   res_value;
  logic [CW-1:0]  res_count;

  assign res_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || st.fire;

  // input register: take an item when empty or when the held one completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q     <= s_axis_tdata[OpW-1:0];
      in_amount_q <= s_axis_tdata[OpW +: W];
    end
  end

  // operation logic and counter state
  bcu_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (in_valid_q),
    .item_op_i     (in_op_q),
    .item_amount_i (in_amount_q),
    .res_free_i    (res_free),
    .status_o      (st),
    .value_o       (res_value),
    .count_o       (res_count)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st.fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st.fire) begin
      out_value_q <= res_value;
      out_count_q <= res_count;
      out_acc_q   <= st.accepted;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_acc_q, out_count_q, out_value_q});

  // an item completes only into a free result register
  a_fire_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.fire |-> (!out_valid_q || m_axis_tready))
    else $error("item completed into an occupied result register");

  // a history read is outstanding only for an undo held in the input register
  a_fetch_undo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.fetch |-> (in_valid_q && in_op_q == OP_UNDO))
    else $error("history read outstanding without an undo item");

  // only an undo can be rejected
  a_reject_undo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st.fire && !st.accepted) |-> (in_op_q == OP_UNDO))
    else $error("rejection on an item that is not an undo");

  // the history always holds between one entry and its depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_count_q != '0 && out_count_q <= CW'(HISTORY_DEPTH)))
    else $error("history count out of range");

endmodule

`default_nettype wire

// File: sim/bcu_checker.sv
`timescale 1ns / 100ps
// bcu_checker: watches the config port and both item channels of the bounded counter,
// predicts every result from its own copy of the counter state and compares it
// depends on bcu_pkg for the operation codes and register indexes

module bcu_checker
  import bcu_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [CfgIdxW-1:0] cfg_idx_i,
  input  wire  [15:0]        cfg_data_i,
  input  wire                s_axis_tvalid,
  input  wire                s_axis_tready,
  // tdata: operation, amount
  input  wire  [23:0]        s_axis_tdata,
  input  wire                m_axis_tvalid,
  input  wire                m_axis_tready,
  // tdata: current_value, history_count, accepted
  input  wire  [23:0]        m_axis_tdata,
  output int                 results_due_o,
  output int                 fail_count_o
);

  localparam int Depth = 64;

  typedef struct packed {
    logic [15:0] value;
    logic [6:0]  held;
    logic        ok;
  } counter_result_t;

  // configuration as last written
  logic signed [15:0] start_reg;
  logic signed [15:0] lower_reg;
  logic signed [15:0] upper_reg;

  // predicted counter state
  logic signed [15:0] count_q;
  logic signed [15:0] low_q;
  logic signed [15:0] high_q;
  logic signed [15:0] value_log [Depth];
  logic [5:0]         top_q;
  logic [6:0]         held_q;

  counter_result_t expected_results [$];

  // push a new counter value; the oldest entry is overwritten once full
  function automatic void push_value(input int v);
    count_q = 16'(v);
    top_q = top_q + 6'd1;
    value_log[top_q] = count_q;
    if (held_q < Depth) held_q = held_q + 7'd1;
  endfunction

  // apply one operation to the predicted state and return its result
  function automatic counter_result_t predict_item(input logic [OpW-1:0] op,
                                                   input logic signed [15:0] amt);
    int   v;
    logic ok;
    ok = 1'b1;
    case (op)
      OP_RESTART: begin
        if (start_reg > upper_reg || start_reg < lower_reg || upper_reg <= lower_reg) begin
          low_q = '0;
          high_q = 16'(DefaultHigh);
          count_q = '0;
        end else begin
          low_q = lower_reg;
          high_q = upper_reg;
          count_q = start_reg;
        end
        top_q = '0;
        value_log[0] = count_q;
        held_q = 7'd1;
      end
      OP_ASSIGN: begin
        v = amt;
        if (v < low_q) v = low_q;
        else if (v > high_q) v = high_q;
        push_value(v);
      end
      OP_INCR: begin
        if (count_q < high_q) push_value(int'(count_q) + 1);
      end
      OP_DECR: begin
        if (count_q > low_q) push_value(int'(count_q) - 1);
      end
      OP_ADD, OP_SUB: begin
        v = (op == OP_ADD) ? int'(count_q) + int'(amt) : int'(count_q) - int'(amt);
        if (v > high_q) v = high_q;
        if (v < low_q) v = low_q;
        push_value(v);
      end
      OP_UNDO: begin
        if (amt < 1 || int'(amt) > int'(held_q) - 1) begin
          ok = 1'b0;
        end else begin
          top_q = top_q - amt[5:0];
          held_q = held_q - amt[6:0];
          count_q = value_log[top_q];
        end
      end
      default: ;
    endcase
    return '{value: count_q, held: held_q, ok: ok};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    counter_result_t want;
    counter_result_t seen;
    if (!rst_ni) begin
      start_reg = '0;
      lower_reg = '0;
      upper_reg = 16'(DefaultHigh);
      count_q = '0;
      low_q = '0;
      high_q = 16'(DefaultHigh);
      foreach (value_log[i]) value_log[i] = '0;
      top_q = '0;
      held_q = 7'd1;
      expected_results.delete();
      results_due_o = 0;
      fail_count_o = 0;
    end else begin
      // results first: an item taken at this edge cannot have its result yet
      if (m_axis_tvalid && m_axis_tready) begin
        seen = '{value: m_axis_tdata[15:0], held: m_axis_tdata[22:16], ok: m_axis_tdata[23]};
        if (expected_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result with nothing expected: value %0d count %0d accepted %0b",
                     $realtime, $signed(seen.value), seen.held, seen.ok);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (seen.value !== want.value || seen.held !== want.held || seen.ok !== want.ok) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch: value exp %0d got %0d, count exp %0d got %0d, %s %0b got %0b",
                       $realtime, $signed(want.value), $signed(seen.value), want.held,
                       seen.held, "accepted exp", want.ok, seen.ok);
            fail_count_o++;
          end
        end
      end
      // each accepted item yields exactly one result, queued at the tail
      if (s_axis_tvalid && s_axis_tready)
        expected_results.insert(expected_results.size(),
                                predict_item(s_axis_tdata[2:0], s_axis_tdata[18:3]));
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START: start_reg = cfg_data_i;
          CFG_LOWER: lower_reg = cfg_data_i;
          CFG_UPPER: upper_reg = cfg_data_i;
          default: ;
        endcase
      end
      results_due_o = expected_results.size();
    end
  end

endmodule

// File: sim/tb_bounded_counter_with_undo.sv
`timescale 1ns / 100ps
// tb_bounded_counter_with_undo: drives items and register writes into the bounded counter
// depends on bcu_pkg, bounded_counter_with_undo and bcu_checker

module tb_bounded_counter_with_undo;
  import bcu_pkg::*;

  // unused operation code, the block holds its state
  localparam logic [OpW-1:0]     OpNone = 3'd7;
  // register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  // tdata: operation, amount
  logic [23:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  // tdata: current_value, history_count, accepted
  logic [23:0]        m_axis_tdata;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int results_due;
  int fail_count;

  bounded_counter_with_undo uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bcu_checker u_result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .results_due_o (results_due),
    .fail_count_o  (fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, or a long hold-off when asked for
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // offer one item after an optional idle gap, return at the edge that takes it
  task automatic send_item(input logic [OpW-1:0] op, input logic [15:0] amount);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, amount, op};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_due != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // write start value and both limits, optionally poke the spare index too
  task automatic load_limits(input logic [15:0] start, input logic [15:0] lower,
                             input logic [15:0] upper, input bit spare);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_START;
    cfg_data_i <= start;
    @(posedge clk_i);
    cfg_idx_i <= CFG_LOWER;
    cfg_data_i <= lower;
    @(posedge clk_i);
    cfg_idx_i <= CFG_UPPER;
    cfg_data_i <= upper;
    @(posedge clk_i);
    if (spare) begin
      cfg_idx_i <= CfgSpare;
      cfg_data_i <= 16'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // operand mix: small values, the extremes and the full range
  function automatic logic [15:0] pick_amount(input bit for_undo);
    int sel;
    sel = $urandom_range(9);
    if (for_undo) begin
      if (sel < 6) return 16'($urandom_range(1, 6));
      if (sel < 8) return 16'($urandom_range(7, 64));
      if (sel == 8) return 16'(int'($urandom_range(0, 3)) - 2);
      return 16'($urandom);
    end
    if (sel < 4) return 16'($urandom_range(0, 40) - 20);
    if (sel < 6) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic send_random_item();
    int             pick;
    logic [OpW-1:0] op;
    pick = $urandom_range(99);
    if (pick < 2) op = OP_RESTART;
    else if (pick < 4) op = OpNone;
    else if (pick < 20) op = OP_ASSIGN;
    else if (pick < 36) op = OP_INCR;
    else if (pick < 52) op = OP_DECR;
    else if (pick < 67) op = OP_ADD;
    else if (pick < 82) op = OP_SUB;
    else op = OP_UNDO;
    send_item(op, pick_amount(op == OP_UNDO));
  endtask

  // wrap the history round, then unwind it from a full stack
  task automatic fill_and_unwind();
    repeat ($urandom_range(64, 80)) begin
      if ($urandom_range(1)) send_item(OP_ASSIGN, 16'($urandom));
      else send_item(OP_ADD, 16'($urandom_range(0, 6) - 3));
    end
    send_item(OP_UNDO, 16'd64);
    send_item(OP_UNDO, 16'd63);
    send_item(OP_UNDO, 16'd1);
  endtask

  // stimulus and verdict
  initial begin
    logic [15:0] lo;
    logic [15:0] hi;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_START;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset limits 0..1000
    send_item(OP_UNDO, 16'd0);          // zero steps
    send_item(OP_UNDO, 16'd1);          // only one entry held
    send_item(OP_DECR, 16'd0);          // at the low limit
    send_item(OP_INCR, 16'd0);
    send_item(OP_ASSIGN, 16'h7fff);     // clamped to the high limit
    send_item(OP_INCR, 16'd0);          // at the high limit
    send_item(OP_ASSIGN, 16'h8000);     // clamped to the low limit
    send_item(OP_ADD, 16'h7fff);
    send_item(OP_SUB, 16'h8000);        // negating the most negative operand
    send_item(OP_SUB, 16'h7fff);
    send_item(OP_ADD, 16'h8000);
    send_item(OP_UNDO, 16'd2);
    send_item(OP_UNDO, 16'hffff);       // negative step count
    send_item(OpNone, 16'hffff);
    send_item(OP_UNDO, 16'h7fff);
    send_item(OP_RESTART, 16'd0);
    wait_until_idle();

    // directed: full 16-bit range
    load_limits(16'h7fff, 16'h8000, 16'h7fff, 1'b1);
    send_item(OP_RESTART, 16'd0);
    send_item(OP_INCR, 16'd0);
    send_item(OP_ADD, 16'h7fff);
    send_item(OP_ASSIGN, 16'h8000);
    send_item(OP_DECR, 16'd0);
    send_item(OP_SUB, 16'h7fff);
    wait_until_idle();

    // directed: restart fallbacks - inverted limits, equal limits, start out of range
    load_limits(16'd0, 16'd10, 16'd5, 1'b0);
    send_item(OP_RESTART, 16'd0);
    wait_until_idle();
    load_limits(16'd5, 16'd5, 16'd5, 1'b0);
    send_item(OP_RESTART, 16'd0);
    wait_until_idle();
    load_limits(16'd2000, 16'd0, 16'd1000, 1'b0);
    send_item(OP_RESTART, 16'd0);
    wait_until_idle();

    // random phases, each with its own limits and idling
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      lo = 16'($urandom);
      hi = 16'($urandom);
      case (phase)
        0: load_limits(16'd0, 16'd0, 16'd1000, 1'b0);
        1: load_limits(16'h8000, 16'h8000, 16'h7fff, 1'b0);
        2: load_limits(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
        3: load_limits(16'd3, 16'hfffe, 16'd7, 1'b0);
        4: load_limits(16'($urandom), lo, hi, 1'b1);
        5: load_limits(16'd0, 16'hffff, 16'd0, 1'b0);
        6: load_limits(16'hfffb, 16'hfff6, 16'hfffd, 1'b0);
        default: load_limits(($signed(lo) < $signed(hi)) ? lo : hi, lo, hi, 1'b1);
      endcase
      send_item(OP_RESTART, 16'($urandom));
      for (int n = 0; n < 70; n++) begin
        if (n == 30 && phase[0]) fill_and_unwind();
        // long receiver hold-off while items keep coming
        if (n == 10 && phase == 0) begin
          hold_cycles = 60;
          repeat (12) send_random_item();
        end
        // sender waits for every result mid-phase
        if (n == 40 && phase == 2) wait_until_idle();
        send_random_item();
      end
      wait_until_idle();
    end

    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
